>>> rtl/fccm_pkg.sv
// Package with the shared types and constants of the cluster chain manager.
package fccm_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 4096;
  localparam int unsigned LIM_W = 13;
  localparam int unsigned CLU_W = 12;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ENTRY_W = 28;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;
  localparam logic [LIM_W-1:0] LIMIT_MAX = 13'd8191;
  localparam logic [LIM_W-1:0] FIRST_DATA_CLUSTER = 13'd2;
  localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 28'hFFFFFFF;

  typedef enum logic [2:0] {
    ACT_READ         = 3'd0,
    ACT_WRITE        = 3'd1,
    ACT_ALLOC        = 3'd2,
    ACT_APPEND       = 3'd3,
    ACT_ALLOC_APPEND = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_BROKEN  = 2'd2,
    STAT_RANGE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_READ_WAIT,
    S_WALK,
    S_SCAN,
    S_LINK,
    S_MARK,
    S_FINISH
  } state_t;

endpackage

>>> rtl/fat_cluster_chain_manager.sv
// Cluster chain manager: allocation table memory and its operation sequencer.
//
// Words enter on the in_ channel and each one yields exactly one result word on the
// out_ channel; both channels use valid and stall. The cfg_ port sets the number of
// clusters in use and may be written at any time the block is idle.
// After reset a clearing pass writes zero to every table entry, one per cycle, so
// in_stall stays high until the pass is through and the first word can be taken.
// One word is worked on at a time, all of it through the single table memory:
// a read goes from dispatch through a wait for the registered table data to the
// finish state, a write is made in dispatch, and the next word is taken once the
// result is handed over. Allocation reads one entry a cycle from cluster 2 upwards;
// an append follows the chain at one entry a cycle and then makes its two writes,
// the link from the old tail and the end mark on the new cluster.
// The result sits in an output register; while the receiver stalls it holds, and
// the block still takes and works on the next word, waiting only to hand over its
// own result until the register is free.
module fat_cluster_chain_manager
  import fccm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [LIM_W-1:0]      cfg_cluster_limit,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_action,
  input  logic [CLU_W-1:0]      in_cluster,
  input  logic [WORD_W-1:0]     in_write_value,
  input  logic [CLU_W-1:0]      in_link_cluster,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [CLU_W-1:0]      out_result_cluster,
  output logic [ENTRY_W-1:0]    out_entry_value
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [LIM_W-1:0] LIM_CAP =
    (TABLE_ENTRIES > 8191) ? LIMIT_MAX : LIM_W'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  logic [WORD_W-1:0] table_mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] mem_rdata_r;
  logic [AW-1:0]     mem_raddr;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_we;

  state_t            state_r, state_nxt;
  logic [LIM_W-1:0]  limit_r;
  logic [LIM_W-1:0]  lim;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [2:0]        action_r, action_nxt;
  logic [LIM_W-1:0]  clu_r, clu_nxt;
  logic [WORD_W-1:0] wval_r, wval_nxt;
  logic [LIM_W-1:0]  link_r, link_nxt;
  logic [LIM_W-1:0]  cur_r, cur_nxt;
  logic [LIM_W-1:0]  tail_r, tail_nxt;
  logic [LIM_W-1:0]  steps_r, steps_nxt;
  logic [LIM_W-1:0]  scan_r, scan_nxt;
  logic [LIM_W-1:0]  chk_addr_r, chk_addr_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [CLU_W-1:0]  res_cluster_r, res_cluster_nxt;
  logic [ENTRY_W-1:0] res_entry_r, res_entry_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [CLU_W-1:0]  out_cluster_r, out_cluster_nxt;
  logic [ENTRY_W-1:0] out_entry_r, out_entry_nxt;
  logic [ENTRY_W-1:0] rd_entry;

  assign lim = (limit_r > LIM_CAP) ? LIM_CAP : limit_r;
  assign rd_entry = mem_rdata_r[ENTRY_W-1:0];

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_cluster = out_cluster_r;
  assign out_entry_value    = out_entry_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= table_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      limit_r     <= LIMIT_RESET;
      clr_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_cluster_limit;
      end
      clr_r       <= clr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r      <= action_nxt;
    clu_r         <= clu_nxt;
    wval_r        <= wval_nxt;
    link_r        <= link_nxt;
    cur_r         <= cur_nxt;
    tail_r        <= tail_nxt;
    steps_r       <= steps_nxt;
    scan_r        <= scan_nxt;
    chk_addr_r    <= chk_addr_nxt;
    res_status_r  <= res_status_nxt;
    res_cluster_r <= res_cluster_nxt;
    res_entry_r   <= res_entry_nxt;
    out_status_r  <= out_status_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_entry_r   <= out_entry_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    action_nxt      = action_r;
    clu_nxt         = clu_r;
    wval_nxt        = wval_r;
    link_nxt        = link_r;
    cur_nxt         = cur_r;
    tail_nxt        = tail_r;
    steps_nxt       = steps_r;
    scan_nxt        = scan_r;
    chk_addr_nxt    = chk_addr_r;
    chk_vld_nxt     = chk_vld_r;
    res_status_nxt  = res_status_r;
    res_cluster_nxt = res_cluster_r;
    res_entry_nxt   = res_entry_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_cluster_nxt = out_cluster_r;
    out_entry_nxt   = out_entry_r;
    mem_raddr       = AW'(cur_r);
    mem_waddr       = AW'(link_r);
    mem_wdata       = '0;
    mem_we          = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          action_nxt = in_action;
          clu_nxt    = LIM_W'(in_cluster);
          wval_nxt   = in_write_value;
          link_nxt   = LIM_W'(in_link_cluster);
          state_nxt  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_status_nxt  = STAT_OK;
        res_cluster_nxt = '0;
        res_entry_nxt   = '0;
        case (action_r)
          ACT_READ: begin
            if (clu_r >= lim) begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = S_FINISH;
            end else begin
              mem_raddr = AW'(clu_r);
              state_nxt = S_READ_WAIT;
            end
          end
          ACT_WRITE: begin
            if (clu_r >= lim) begin
              res_status_nxt = STAT_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(clu_r);
              mem_wdata = wval_r;
            end
            state_nxt = S_FINISH;
          end
          ACT_ALLOC: begin
            scan_nxt    = FIRST_DATA_CLUSTER;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end
          ACT_APPEND, ACT_ALLOC_APPEND: begin
            if ((clu_r >= lim) || ((action_r == ACT_APPEND) && (link_r >= lim))) begin
              res_status_nxt = STAT_RANGE;
              state_nxt      = S_FINISH;
            end else begin
              mem_raddr = AW'(clu_r);
              cur_nxt   = clu_r;
              steps_nxt = LIM_W'(1);
              state_nxt = S_WALK;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end

      S_READ_WAIT: begin
        res_entry_nxt = rd_entry;
        state_nxt     = S_FINISH;
      end

      S_WALK: begin
        if (rd_entry == END_OF_CHAIN) begin
          tail_nxt = cur_r;
          if (action_r == ACT_APPEND) begin
            state_nxt = S_LINK;
          end else begin
            scan_nxt    = FIRST_DATA_CLUSTER;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end
        end else if ((rd_entry >= ENTRY_W'(lim)) || (steps_r == lim)) begin
          res_status_nxt = STAT_BROKEN;
          state_nxt      = S_FINISH;
        end else begin
          mem_raddr = AW'(rd_entry);
          cur_nxt   = LIM_W'(rd_entry);
          steps_nxt = steps_r + 1'b1;
        end
      end

      S_SCAN: begin
        mem_raddr = AW'(scan_r);
        if (chk_vld_r && (rd_entry == '0)) begin
          link_nxt        = chk_addr_r;
          res_cluster_nxt = CLU_W'(chk_addr_r);
          chk_vld_nxt     = 1'b0;
          state_nxt       = (action_r == ACT_ALLOC) ? S_MARK : S_LINK;
        end else if (scan_r < lim) begin
          chk_vld_nxt  = 1'b1;
          chk_addr_nxt = scan_r;
          scan_nxt     = scan_r + 1'b1;
        end else if (!chk_vld_r) begin
          res_status_nxt = STAT_NO_FREE;
          state_nxt      = S_FINISH;
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end

      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(tail_r);
        mem_wdata = WORD_W'(link_r);
        state_nxt = S_MARK;
      end

      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(link_r);
        mem_wdata = WORD_W'(END_OF_CHAIN);
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_cluster_nxt = res_cluster_r;
          out_entry_nxt   = res_entry_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> bench/tb_fat_cluster_chain_manager.sv
// Self-checking testbench for the cluster chain manager: table operations under random flow control.
module tb_fat_cluster_chain_manager;
  import fccm_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int unsigned LONG_HOLD_AT = 300;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned PHASES = 10;

  typedef struct {
    logic [2:0]        action;
    logic [CLU_W-1:0]  cluster;
    logic [WORD_W-1:0] write_value;
    logic [CLU_W-1:0]  link_cluster;
  } cluster_op_t;

  typedef struct {
    status_t            status;
    logic [CLU_W-1:0]   result_cluster;
    logic [ENTRY_W-1:0] entry_value;
  } op_outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [LIM_W-1:0]    cfg_cluster_limit = LIMIT_RESET;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          in_action = ACT_READ;
  logic [CLU_W-1:0]    in_cluster = '0;
  logic [WORD_W-1:0]   in_write_value = '0;
  logic [CLU_W-1:0]    in_link_cluster = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic [CLU_W-1:0]    out_result_cluster;
  logic [ENTRY_W-1:0]  out_entry_value;

  logic [WORD_W-1:0]   fat_words [DEF_TABLE_ENTRIES];
  logic [LIM_W-1:0]    limit_setting = LIMIT_RESET;
  cluster_op_t         pending_ops [$];
  op_outcome_t         expected_outcomes [$];
  cluster_op_t         offered_op;
  int unsigned         burst_left = 1;
  int unsigned         gap_left = 0;
  int unsigned         hold_left = 0;
  bit                  long_hold_done = 1'b0;
  int unsigned         stall_pct = 0;
  int unsigned         pattern_left = 0;
  int unsigned         words_returned = 0;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         phase_limit [PHASES] = '{16, 64, 3, 200, 8191, 37, 4096, 8, 1000, 128};
  int unsigned         phase_items [PHASES] = '{180, 200, 80, 180, 50, 180, 60, 120, 100, 200};

  fat_cluster_chain_manager #(
    .TABLE_ENTRIES(DEF_TABLE_ENTRIES)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_cluster_limit (cfg_cluster_limit),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_cluster        (in_cluster),
    .in_write_value    (in_write_value),
    .in_link_cluster   (in_link_cluster),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_cluster(out_result_cluster),
    .out_entry_value   (out_entry_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned usable_limit(input logic [LIM_W-1:0] setting);
    return (setting > DEF_TABLE_ENTRIES) ? DEF_TABLE_ENTRIES : int'(setting);
  endfunction

  function automatic bit find_chain_end(input int unsigned head, input int unsigned lim,
                                        output int unsigned tail);
    int unsigned cur;
    int unsigned n;
    logic [ENTRY_W-1:0] nxt;
    cur = head;
    tail = 0;
    for (n = 0; n < lim; n++) begin
      nxt = fat_words[cur][ENTRY_W-1:0];
      if (nxt == END_OF_CHAIN) begin
        tail = cur;
        return 1'b1;
      end
      if (nxt >= lim) return 1'b0;
      cur = nxt;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned first_free_cluster(input int unsigned lim);
    int unsigned c;
    for (c = FIRST_DATA_CLUSTER; c < lim; c++) begin
      if (fat_words[c][ENTRY_W-1:0] == '0) return c;
    end
    return 0;
  endfunction

  function automatic op_outcome_t apply_to_table(input cluster_op_t op);
    op_outcome_t res;
    int unsigned lim;
    int unsigned tail;
    int unsigned fresh;
    lim = usable_limit(limit_setting);
    res.status = STAT_OK;
    res.result_cluster = '0;
    res.entry_value = '0;
    case (op.action)
      ACT_READ: begin
        if (op.cluster >= lim) res.status = STAT_RANGE;
        else res.entry_value = fat_words[op.cluster][ENTRY_W-1:0];
      end
      ACT_WRITE: begin
        if (op.cluster >= lim) res.status = STAT_RANGE;
        else fat_words[op.cluster] = op.write_value;
      end
      ACT_ALLOC: begin
        fresh = first_free_cluster(lim);
        if (fresh == 0) begin
          res.status = STAT_NO_FREE;
        end else begin
          fat_words[fresh] = WORD_W'(END_OF_CHAIN);
          res.result_cluster = CLU_W'(fresh);
        end
      end
      ACT_APPEND: begin
        if (op.cluster >= lim || op.link_cluster >= lim) begin
          res.status = STAT_RANGE;
        end else if (!find_chain_end(op.cluster, lim, tail)) begin
          res.status = STAT_BROKEN;
        end else begin
          // The tail is linked first, so a cluster linked to itself ends as the end mark.
          fat_words[tail] = WORD_W'(op.link_cluster);
          fat_words[op.link_cluster] = WORD_W'(END_OF_CHAIN);
        end
      end
      ACT_ALLOC_APPEND: begin
        if (op.cluster >= lim) begin
          res.status = STAT_RANGE;
        end else if (!find_chain_end(op.cluster, lim, tail)) begin
          res.status = STAT_BROKEN;
        end else begin
          fresh = first_free_cluster(lim);
          if (fresh == 0) begin
            res.status = STAT_NO_FREE;
          end else begin
            fat_words[tail] = WORD_W'(fresh);
            fat_words[fresh] = WORD_W'(END_OF_CHAIN);
            res.result_cluster = CLU_W'(fresh);
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [CLU_W-1:0] pick_cluster(input int unsigned lim);
    int unsigned hot;
    int unsigned roll;
    hot = (lim > 128) ? 128 : lim;
    roll = $urandom_range(99, 0);
    if (roll < 12) return CLU_W'($urandom);
    if (roll < 22) return CLU_W'($urandom_range(lim - 1, 0));
    return CLU_W'($urandom_range(hot - 1, 0));
  endfunction

  function automatic cluster_op_t random_op(input int unsigned lim);
    cluster_op_t op;
    int unsigned roll;
    int unsigned sel;
    roll = $urandom_range(99, 0);
    if (roll < 10) op.action = ACT_READ;
    else if (roll < 25) op.action = ACT_WRITE;
    else if (roll < 43) op.action = ACT_ALLOC;
    else if (roll < 63) op.action = ACT_APPEND;
    else if (roll < 95) op.action = ACT_ALLOC_APPEND;
    else op.action = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    op.cluster = pick_cluster(lim);
    op.link_cluster = pick_cluster(lim);
    sel = $urandom_range(9, 0);
    if (sel < 2) op.write_value = '0;
    else if (sel < 5) op.write_value = WORD_W'(pick_cluster(lim));
    else if (sel == 5) op.write_value = {4'($urandom), 16'h0000, pick_cluster(lim)};
    else if (sel < 8) op.write_value = {4'($urandom), END_OF_CHAIN};
    else op.write_value = $urandom;
    return op;
  endfunction

  task automatic queue_op(input logic [2:0] act, input int unsigned clu,
                          input logic [WORD_W-1:0] value, input int unsigned link);
    cluster_op_t op;
    op.action = act;
    op.cluster = CLU_W'(clu);
    op.write_value = value;
    op.link_cluster = CLU_W'(link);
    pending_ops.push_back(op);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_outcomes.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_cluster_limit(input logic [LIM_W-1:0] value);
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_cluster_limit <= value;
    limit_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Sender: bursts of words with random gaps; a stalled word is held unchanged.
  always @(posedge clk) begin
    if (in_valid && !in_stall) expected_outcomes.push_back(apply_to_table(offered_op));
    if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        offered_op = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_action <= offered_op.action;
        in_cluster <= offered_op.cluster;
        in_write_value <= offered_op.write_value;
        in_link_cluster <= offered_op.link_cluster;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(24, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result word and stalls on a pattern of changing density, with one long hold.
  always @(posedge clk) begin
    op_outcome_t want;
    logic stall_next;
    if (out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $error("result word with nothing expected: status %0d, cluster %0d, entry %0h",
               out_status, out_result_cluster, out_entry_value);
        mismatch_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_result_cluster !== want.result_cluster) begin
          $error("result_cluster: expected %0d, got %0d", want.result_cluster,
                 out_result_cluster);
          mismatch_count++;
        end
        if (out_entry_value !== want.entry_value) begin
          $error("entry_value: expected %0h, got %0h", want.entry_value, out_entry_value);
          mismatch_count++;
        end
      end
      words_returned++;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else if (!long_hold_done && words_returned >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      stall_next = 1'b1;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(3, 0))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
        pattern_left = $urandom_range(256, 32);
      end else begin
        pattern_left--;
      end
      stall_next = ($urandom_range(99, 0) < stall_pct);
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_fat_cluster_chain_manager: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned k;
    int unsigned lim;
    for (k = 0; k < DEF_TABLE_ENTRIES; k++) fat_words[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_cluster_limit(LIMIT_RESET);
    queue_op(ACT_READ, 0, $urandom, 0);
    queue_op(ACT_READ, 4095, $urandom, 4095);
    queue_op(ACT_ALLOC, 0, '0, 0);
    queue_op(ACT_ALLOC, 4095, '1, 4095);
    queue_op(ACT_APPEND, 2, '0, 4095);
    queue_op(ACT_ALLOC_APPEND, 2, '0, 0);
    queue_op(ACT_WRITE, 5, 32'hFFFF_FFFF, 0);
    queue_op(ACT_READ, 5, '0, 0);
    queue_op(ACT_WRITE, 6, 32'hF000_0000, 0);
    queue_op(ACT_ALLOC, 0, '0, 0);
    queue_op(ACT_WRITE, 7, 32'h0000_1000, 0);
    queue_op(ACT_APPEND, 7, '0, 8);
    queue_op(ACT_WRITE, 8, 32'h0000_0008, 0);
    queue_op(ACT_ALLOC_APPEND, 8, '0, 0);
    queue_op(ACT_APPEND, 3, '0, 3);
    queue_op(ACT_READ, 3, '0, 0);
    queue_op(ACT_SPARE_HI, 4095, '1, 4095);
    queue_op(ACT_SPARE_LO, 0, '0, 0);
    wait_until_drained();

    write_cluster_limit(LIM_W'(3));
    queue_op(ACT_READ, 3, '0, 0);
    queue_op(ACT_WRITE, 4095, '1, 0);
    queue_op(ACT_APPEND, 0, '0, 3);
    queue_op(ACT_ALLOC, 0, '0, 0);
    queue_op(ACT_WRITE, 0, WORD_W'(END_OF_CHAIN), 0);
    queue_op(ACT_APPEND, 0, '0, 1);
    queue_op(ACT_ALLOC_APPEND, 0, '0, 0);
    wait_until_drained();

    write_cluster_limit(LIM_W'(2));
    queue_op(ACT_ALLOC, 0, '0, 0);
    queue_op(ACT_READ, 2, '0, 0);
    wait_until_drained();

    for (p = 0; p < PHASES; p++) begin
      write_cluster_limit(LIM_W'(phase_limit[p]));
      lim = usable_limit(LIM_W'(phase_limit[p]));
      for (k = 0; k < phase_items[p]; k++) pending_ops.push_back(random_op(lim));
      wait_until_drained();
    end

    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_fat_cluster_chain_manager: done, clean");
    end else begin
      $display("tb_fat_cluster_chain_manager: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/fccm_pkg.sv
rtl/fat_cluster_chain_manager.sv
bench/tb_fat_cluster_chain_manager.sv
